@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ rtl/core/rmth_pkg.sv @@
// ----------------------------------------------------------------------------
// rmth_pkg
// Types and fixed constants of the two-heap running median.
// ----------------------------------------------------------------------------
package rmth_pkg;

  // sample_count field width
  localparam int CNT_W = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DN_RD,
    ST_DN_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POP,
    ST_POP_WT,
    ST_DONE
  } state_t;

  // which heap operation the sift sequencer is running
  typedef enum logic [1:0] {
    PH_XCHG,   // exchange at upper top, sift down
    PH_PUSHL,  // push into lower, sift up
    PH_POPL,   // pop lower, sift down
    PH_PUSHU   // push into upper, sift up
  } phase_t;

endpackage

@@ rtl/core/running_median_two_heaps.sv @@
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median of a signed sample stream, kept in two heap memories.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per sample, in_tdata[SAMPLE_BITS-1:0] signed.
//   out_* : one beat per sample: twice the median, the count of stored
//           samples and an accepted flag (0 when the store is full).
//   Samples are taken one at a time; in_tready is high only while idle.
//   Per sample: up to four sifts (exchange at the upper top, push lower,
//   pop lower, push upper); every heap level of a sift is a read, then a
//   compare and write on one memory, over the single read-modify-write
//   path into each heap memory. in_tready returns with each new result beat.
//   A full store answers with the state untouched.
//   Results sit in an output register; the next sample is accepted while
//   that beat waits. A sequencer finishing with the register still full
//   holds until out_tready.
//   Reset (rst_n low, synchronous) empties both heaps by clearing the
//   sizes; heap memories are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module running_median_two_heaps #(
  parameter int HEAP_CAPACITY = 512,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // [SAMPLE_BITS-1:0] sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // median_twice [SAMPLE_BITS:0], sample_count 11 bits, accepted 1 bit
  output logic [((SAMPLE_BITS+1+rmth_pkg::CNT_W+1+7)/8)*8-1:0] out_tdata
);
  import rmth_pkg::*;

  localparam int AW    = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
  localparam int CW    = $clog2(HEAP_CAPACITY + 1);
  localparam int IW    = AW + 2;
  localparam int SB    = SAMPLE_BITS;
  localparam int MW    = SAMPLE_BITS + 1;
  localparam int OUT_W = ((MW + CNT_W + 1 + 7) / 8) * 8;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic signed [SB-1:0] hole_r, hole_nxt;    // element being sifted
  logic signed [SB-1:0] moved_r, moved_nxt;  // element handed to next heap
  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] n_r, n_nxt;                 // size bound for sift down
  logic [CW-1:0] lsize_r, lsize_nxt;
  logic [CW-1:0] usize_r, usize_nxt;
  logic acc_r, acc_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  // memory ports
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [SB-1:0] wdata;
  logic [SB-1:0] l_rd_a, l_rd_b, l_top, u_rd_a, u_rd_b, u_top;
  logic          sel_upper;

  logic signed [SB-1:0] rd_a, rd_b, ltop, utop, best_val;
  logic [IW-1:0] lc_w, rc_w;
  logic          l_ok, r_ok, go_l, go_r, up_go;
  logic [AW-1:0] par;
  logic          sift_done;
  logic          in_fire, out_load;
  logic signed [SB-1:0] in_sample;
  logic signed [MW-1:0] med;
  logic [CW:0]   cnt_w;

  function automatic logic above(input logic signed [SB-1:0] a,
                                 input logic signed [SB-1:0] b,
                                 input logic is_min);
    above = is_min ? (a < b) : (a > b);
  endfunction

  rmth_heap #(.DEPTH(HEAP_CAPACITY), .DW(SB), .AW(AW)) u_lower (
    .clk(clk), .we(we && !sel_upper), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b),
    .rdata_a(l_rd_a), .rdata_b(l_rd_b), .top(l_top)
  );

  rmth_heap #(.DEPTH(HEAP_CAPACITY), .DW(SB), .AW(AW)) u_upper (
    .clk(clk), .we(we && sel_upper), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b),
    .rdata_a(u_rd_a), .rdata_b(u_rd_b), .top(u_top)
  );

  assign sel_upper = (phase_r == PH_XCHG) || (phase_r == PH_PUSHU);
  assign rd_a      = sel_upper ? $signed(u_rd_a) : $signed(l_rd_a);
  assign rd_b      = sel_upper ? $signed(u_rd_b) : $signed(l_rd_b);
  assign ltop      = $signed(l_top);
  assign utop      = $signed(u_top);
  assign in_sample = $signed(in_tdata[SB-1:0]);

  // children and parent of the current hole
  assign lc_w = {1'b0, pos_r, 1'b1};
  assign rc_w = lc_w + IW'(1);
  assign l_ok = lc_w < IW'(n_r);
  assign r_ok = rc_w < IW'(n_r);
  assign go_l = l_ok && above(rd_a, hole_r, sel_upper);
  assign best_val = go_l ? rd_a : hole_r;
  assign go_r = r_ok && above(rd_b, best_val, sel_upper);
  assign par  = AW'((pos_r - AW'(1)) >> 1);
  assign up_go = above(hole_r, rd_a, sel_upper);

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  assign sift_done = ((state_r == ST_DN_CMP) && !go_l && !go_r) ||
                     ((state_r == ST_UP_RD) && (pos_r == '0)) ||
                     ((state_r == ST_UP_CMP) && !up_go);

  // result: tops are settled once the sequencer reaches ST_DONE
  always_comb begin
    if (usize_r == '0) begin
      med = '0;
    end else if (lsize_r == usize_r) begin
      med = {ltop[SB-1], ltop} + {utop[SB-1], utop};
    end else begin
      med = {utop, 1'b0};
    end
  end
  assign cnt_w = {1'b0, lsize_r} + {1'b0, usize_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (lsize_r == CW'(HEAP_CAPACITY)) begin
            state_nxt = ST_DONE;
          end else if (usize_r == '0 || in_sample <= utop) begin
            state_nxt = ST_UP_RD;
          end else begin
            state_nxt = ST_DN_RD;
          end
        end
      end
      ST_DN_RD:  state_nxt = ST_DN_CMP;
      ST_DN_CMP: begin
        if (go_l || go_r) begin
          state_nxt = ST_DN_RD;
        end
      end
      ST_UP_RD: begin
        if (pos_r != '0) begin
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (up_go) begin
          state_nxt = ST_UP_RD;
        end
      end
      ST_POP:    state_nxt = ST_POP_WT;
      ST_POP_WT: state_nxt = ST_DN_RD;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
    if (sift_done) begin
      case (phase_r)
        PH_XCHG:  state_nxt = ST_UP_RD;
        PH_PUSHL: state_nxt = (lsize_r > usize_r) ? ST_POP : ST_DONE;
        PH_POPL:  state_nxt = ST_UP_RD;
        PH_PUSHU: state_nxt = ST_DONE;
        default:  state_nxt = ST_DONE;
      endcase
    end
  end

  // datapath and memory control
  always_comb begin
    phase_nxt     = phase_r;
    hole_nxt      = hole_r;
    moved_nxt     = moved_r;
    pos_nxt       = pos_r;
    n_nxt         = n_r;
    lsize_nxt     = lsize_r;
    usize_nxt     = usize_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = hole_r;
    raddr_a       = '0;
    raddr_b       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          hole_nxt = in_sample;
          if (lsize_r == CW'(HEAP_CAPACITY)) begin
            acc_nxt = 1'b0;
          end else if (usize_r == '0 || in_sample <= utop) begin
            acc_nxt   = 1'b1;
            phase_nxt = PH_PUSHL;
            pos_nxt   = lsize_r[AW-1:0];
            lsize_nxt = lsize_r + CW'(1);
          end else begin
            // sample takes the upper top, old top goes down
            acc_nxt   = 1'b1;
            moved_nxt = utop;
            phase_nxt = PH_XCHG;
            pos_nxt   = '0;
            n_nxt     = usize_r;
          end
        end
      end
      ST_DN_RD: begin
        raddr_a = lc_w[AW-1:0];
        raddr_b = rc_w[AW-1:0];
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (go_r) begin
          wdata   = rd_b;
          pos_nxt = rc_w[AW-1:0];
        end else if (go_l) begin
          wdata   = rd_a;
          pos_nxt = lc_w[AW-1:0];
        end
      end
      ST_UP_RD: begin
        raddr_a = par;
        if (pos_r == '0) begin
          we = 1'b1;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (up_go) begin
          wdata   = rd_a;
          pos_nxt = par;
        end
      end
      ST_POP: begin
        moved_nxt = ltop;
        lsize_nxt = lsize_r - CW'(1);
        raddr_a   = AW'(lsize_r - CW'(1));
      end
      ST_POP_WT: begin
        hole_nxt = rd_a;
        pos_nxt  = '0;
        n_nxt    = lsize_r;
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({acc_r, CNT_W'(cnt_w), med});
        end
      end
      default: ;
    endcase
    if (sift_done) begin
      case (phase_r)
        PH_XCHG: begin
          hole_nxt  = moved_r;
          phase_nxt = PH_PUSHL;
          pos_nxt   = lsize_r[AW-1:0];
          lsize_nxt = lsize_r + CW'(1);
        end
        PH_PUSHL: begin
          phase_nxt = PH_POPL;
        end
        PH_POPL: begin
          hole_nxt  = moved_r;
          phase_nxt = PH_PUSHU;
          pos_nxt   = usize_r[AW-1:0];
          usize_nxt = usize_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_PUSHL;
      lsize_r     <= '0;
      usize_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      lsize_r     <= lsize_nxt;
      usize_r     <= usize_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hole_r     <= hole_nxt;
    moved_r    <= moved_nxt;
    pos_r      <= pos_nxt;
    n_r        <= n_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/core/rmth_heap.sv @@
// ----------------------------------------------------------------------------
// rmth_heap
// Heap storage: one write port, two registered read ports, cached top entry.
// ----------------------------------------------------------------------------
module rmth_heap #(
  parameter int DEPTH = 512,
  parameter int DW    = 16,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b,
  output logic [DW-1:0] top
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_a_r;
  logic [DW-1:0] rdata_b_r;
  logic [DW-1:0] top_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  // copy of entry 0 so the tops are always at hand
  always_ff @(posedge clk) begin
    if (we && (waddr == '0)) begin
      top_r <= wdata;
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;
  assign top     = top_r;

endmodule

@@ rtl/core/rmth_checker.sv @@
// ----------------------------------------------------------------------------
// rmth_checker
// Port-level checks of the running median, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmth_checker #(
  parameter int HEAP_CAPACITY = 512,
  parameter int SAMPLE_BITS   = 16
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((SAMPLE_BITS+1+rmth_pkg::CNT_W+1+7)/8)*8-1:0] out_tdata
);
  import rmth_pkg::*;

  localparam int MW = SAMPLE_BITS + 1;

  logic           acc;
  logic [CNT_W-1:0] cnt;
  logic           in_fire;

  assign acc     = out_tdata[MW+CNT_W];
  assign cnt     = out_tdata[MW+CNT_W-1:MW];
  assign in_fire = in_tvalid && in_tready;

  // stalled result beat holds
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
              out_tvalid && $stable(out_tdata))
  // one sample in flight at a time
  `ASSERT_NXT(a_busy, clk, rst_n, in_fire, !in_tready)
  // a rejection only happens on a full store
  `ASSERT_IMP(a_reject_full, clk, rst_n, out_tvalid && !acc,
              cnt == CNT_W'(2 * HEAP_CAPACITY))
  // odd count: median is a stored sample, so twice it is even
  `ASSERT_IMP(a_odd_even, clk, rst_n, out_tvalid && cnt[0], !out_tdata[0])

endmodule

bind running_median_two_heaps rmth_checker #(
  .HEAP_CAPACITY(HEAP_CAPACITY),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_rmth_checker (.*);

@@ tb/sv/tb_running_median_two_heaps.sv @@
// ----------------------------------------------------------------------------
// tb_running_median_two_heaps
// Self-checking bench for the two-heap running median. A behavioral model
// keeps the sorted multiset of stored samples and predicts twice the
// median, the stored count and the accepted flag for every sample beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_running_median_two_heaps;
  import rmth_pkg::*;

  localparam int CAP      = 512;
  localparam int SBITS    = 16;
  localparam int IN_W     = ((SBITS + 7) / 8) * 8;
  localparam int OUT_W    = ((SBITS + 1 + CNT_W + 1 + 7) / 8) * 8;
  localparam int STORE_MAX = 2 * CAP;  // both halves full
  localparam int STALL_LIMIT = 20000;

  // packed from the top down: accepted sits in the highest bit
  typedef struct packed {
    logic             accepted;
    logic [CNT_W-1:0] sample_count;
    logic [SBITS:0]   median_twice;
  } median_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  always #1 clk = ~clk;

  running_median_two_heaps #(.HEAP_CAPACITY(CAP), .SAMPLE_BITS(SBITS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Stored samples kept sorted ascending; median read off the middle.
  int sorted_samples[$];
  median_beat_t expected_medians[$];
  int n_errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_rejected = 0;
  int idle_pct = 38;      // per-side idle chance, percent
  int quiet_cycles = 0;
  bit timed_out = 1'b0;

  // Insert the sample into the sorted store unless it is full and work out the beat.
  function automatic median_beat_t predict_median(logic signed [SBITS-1:0] s);
    median_beat_t b;
    int n, pos, med;
    n = sorted_samples.size();
    b.accepted = (n < STORE_MAX);
    if (b.accepted) begin
      pos = 0;
      while (pos < n && sorted_samples[pos] < int'(s)) pos++;
      sorted_samples.insert(pos, int'(s));
      n++;
    end
    // upper half holds the extra element when count is odd
    if (n == 0) med = 0;
    else if (n % 2) med = 2 * sorted_samples[n / 2];
    else med = sorted_samples[n / 2 - 1] + sorted_samples[n / 2];
    b.median_twice = med[SBITS:0];
    b.sample_count = n[CNT_W-1:0];
    return b;
  endfunction

  // One sample beat; driven at the falling edge, accepted at a rising edge.
  // Valid stays up after the beat until the next sample or an idle cycle.
  task automatic send_sample(logic signed [SBITS-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= IN_W'(s);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_medians.insert(expected_medians.size(), predict_median(s));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_medians.size() != 0 && !timed_out) @(negedge clk);
  endtask

  // Result receiver: random backpressure, set at the falling edge.
  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Result checker and no-progress watchdog.
  always @(posedge clk) begin
    median_beat_t got, exp_b;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        timed_out = 1'b1;
        $error("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got = median_beat_t'(out_tdata[SBITS + 1 + CNT_W + 1 - 1:0]);
        n_results++;
        if (expected_medians.size() == 0) begin
          $error("result beat with nothing expected: %h", got);
          n_errors++;
        end else begin
          exp_b = expected_medians.pop_front();
          if (!exp_b.accepted) n_rejected++;
          if (got.median_twice !== exp_b.median_twice) begin
            $error("median_twice: expected %0d, got %0d",
                   $signed(exp_b.median_twice), $signed(got.median_twice));
            n_errors++;
          end
          if (got.sample_count !== exp_b.sample_count) begin
            $error("sample_count: expected %0d, got %0d",
                   exp_b.sample_count, got.sample_count);
            n_errors++;
          end
          if (got.accepted !== exp_b.accepted) begin
            $error("accepted: expected %0d, got %0d", exp_b.accepted, got.accepted);
            n_errors++;
          end
        end
      end
    end
  end

  // Extremes, ties, odd/even counts and sign changes.
  task automatic test_directed();
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0000);
    send_sample(-16'sh0001);
    send_sample(16'sh0001);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(-16'sh8000);
    send_sample(16'sh5555);
    send_sample(-16'sh5556);
    send_sample(16'sh1234);
    send_sample(16'sh1234);
  endtask

  // Mixed-range random samples; the narrow ranges give ties now and then.
  task automatic test_random(int count);
    logic signed [SBITS-1:0] s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: s = SBITS'($urandom_range(15) - 8);
        1: s = SBITS'($urandom);
        2: s = ($urandom_range(1) ? SBITS'(16'sh7fff - $urandom_range(3))
                                  : SBITS'(-16'sh8000 + $urandom_range(3)));
        default: s = SBITS'($urandom_range(2000) - 1000);
      endcase
      send_sample(s);
    end
  endtask

  // Backpressure-free stretch, then pause until all results have come.
  task automatic test_no_idle(int count);
    idle_pct = 0;
    test_random(count);
    wait_drained();
    idle_pct = 38;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(200);
    test_no_idle(150);
    test_random(486);
    fork
      wait_drained();
      wait (timed_out);
    join_any
    repeat (100) @(negedge clk);
    if (timed_out) begin
      $display("Regression FAIL");
    end else begin
      $display("Covered %0d samples, %0d results, %0d rejected on a full store.",
               n_sent, n_results, n_rejected);
      if (n_errors == 0 && expected_medians.size() == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
    end
    $finish;
  end
endmodule

@@ running_median_two_heaps.f @@
+incdir+rtl/core
rtl/core/rmth_pkg.sv
rtl/core/rmth_heap.sv
rtl/core/running_median_two_heaps.sv
rtl/core/rmth_checker.sv
tb/sv/tb_running_median_two_heaps.sv
